FILE: hdl/eit_pkg.sv
// Package: widths, stage counts, register codes and types of the epipolar inlier test.
`timescale 1ns / 1ps
package eit_pkg;

  // Number formats of the ports.
  localparam int COORD_FRAC_BITS = 4;
  localparam int COEF_WIDTH      = 32;
  localparam int LIMIT_PIXELS    = 3;
  localparam int CRD_W           = 16;
  localparam int TAG_W           = 16;
  localparam int SLOT_W          = 32;
  localparam int THR_W           = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_01     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_23     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_45     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_67     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MODEL_VALID = 3'd6;

  localparam logic [THR_W-1:0] THRESH_RESET =
      THR_W'(LIMIT_PIXELS * LIMIT_PIXELS) << (2 * COORD_FRAC_BITS);

  // Datapath widths.
  localparam int PROD1_W  = SLOT_W + CRD_W + 1;   // entry times coordinate
  localparam int LINE_W   = PROD1_W + 1;          // line coefficient, signed
  localparam int MAG_W    = LINE_W - 1;           // magnitude of a line coefficient
  localparam int MAG_LO   = 32;                   // low slice of that magnitude
  localparam int DOT_W    = LINE_W + CRD_W + 1;   // signed point-line residual
  localparam int DMAG_W   = DOT_W - 1;            // its magnitude
  localparam int DHALF    = DMAG_W / 2;           // slice of the residual magnitude
  localparam int SQ_W     = 2 * MAG_W;            // one coefficient squared
  localparam int NORM_W   = SQ_W + 1;             // a^2 + b^2
  localparam int CHUNK_W  = 25;                   // slice of the norm per multiplier
  localparam int NCHUNK   = 4;
  localparam int TPROD_W  = THR_W + CHUNK_W;
  localparam int WIDE_W   = 2 * DMAG_W;           // squared residual and limit

  // Pipeline: two stages form the lines, seven check a side, one holds the result.
  localparam int LINE_STG = 2;
  localparam int SIDE_STG = 7;
  localparam int NSTG     = LINE_STG + SIDE_STG + 1;

  // Decoded configuration seen by the datapath.
  typedef struct packed {
    logic [8:0][SLOT_W-1:0] coef;
    logic [THR_W-1:0]       thresh;
    logic                   model_valid;
  } cfg_t;

  // Read a matrix entry from the low COEF_WIDTH bits of its slot.
  function automatic logic [SLOT_W-1:0] coef_entry(input logic [SLOT_W-1:0] slot);
    logic signed [COEF_WIDTH-1:0] low;
    logic signed [SLOT_W-1:0]     ext;
    low = $signed(slot[COEF_WIDTH-1:0]);
    ext = SLOT_W'(low);
    return ext;
  endfunction

endpackage

FILE: hdl/eit_match_if.sv
// Interface: channel that carries one point correspondence per word.
`timescale 1ns / 1ps
interface eit_match_if;
  import eit_pkg::*;

  logic             valid;
  logic             ready;
  logic [TAG_W-1:0] match_tag;
  logic [CRD_W-1:0] point_a_x;
  logic [CRD_W-1:0] point_a_y;
  logic [CRD_W-1:0] point_b_x;
  logic [CRD_W-1:0] point_b_y;

  modport source (
    output valid, match_tag, point_a_x, point_a_y, point_b_x, point_b_y,
    input  ready
  );

  modport sink (
    input  valid, match_tag, point_a_x, point_a_y, point_b_x, point_b_y,
    output ready
  );
endinterface

FILE: hdl/eit_result_if.sv
// Interface: channel that carries one inlier verdict per word.
`timescale 1ns / 1ps
interface eit_result_if;
  import eit_pkg::*;

  logic             valid;
  logic             ready;
  logic [TAG_W-1:0] tag_out;
  logic             is_inlier;
  logic             line_degenerate;

  modport source (
    output valid, tag_out, is_inlier, line_degenerate,
    input  ready
  );

  modport sink (
    input  valid, tag_out, is_inlier, line_degenerate,
    output ready
  );
endinterface

FILE: hdl/eit_regs.sv
// Configuration registers: matrix entries, threshold and model flag.
`timescale 1ns / 1ps
module eit_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [eit_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [eit_pkg::CFG_DATA_W-1:0] cfg_data,
  output eit_pkg::cfg_t                  cfg
);
  import eit_pkg::*;

  logic [CFG_DATA_W-1:0] coef_pair_01;
  logic [CFG_DATA_W-1:0] coef_pair_23;
  logic [CFG_DATA_W-1:0] coef_pair_45;
  logic [CFG_DATA_W-1:0] coef_pair_67;
  logic [SLOT_W-1:0]     coef_last;
  logic [THR_W-1:0]      threshold_sq;
  logic                  model_valid;

  // Register writes; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_pair_01 <= '0;
      coef_pair_23 <= '0;
      coef_pair_45 <= '0;
      coef_pair_67 <= '0;
      coef_last    <= '0;
      threshold_sq <= THRESH_RESET;
      model_valid  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF_01:     coef_pair_01 <= cfg_data;
        REG_COEF_23:     coef_pair_23 <= cfg_data;
        REG_COEF_45:     coef_pair_45 <= cfg_data;
        REG_COEF_67:     coef_pair_67 <= cfg_data;
        REG_COEF_LAST:   coef_last    <= cfg_data[SLOT_W-1:0];
        REG_THRESHOLD:   threshold_sq <= cfg_data[THR_W-1:0];
        REG_MODEL_VALID: model_valid  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Unpack the slots into sign-extended entries.
  always_comb begin
    cfg.coef[0]     = coef_entry(coef_pair_01[SLOT_W-1:0]);
    cfg.coef[1]     = coef_entry(coef_pair_01[2*SLOT_W-1:SLOT_W]);
    cfg.coef[2]     = coef_entry(coef_pair_23[SLOT_W-1:0]);
    cfg.coef[3]     = coef_entry(coef_pair_23[2*SLOT_W-1:SLOT_W]);
    cfg.coef[4]     = coef_entry(coef_pair_45[SLOT_W-1:0]);
    cfg.coef[5]     = coef_entry(coef_pair_45[2*SLOT_W-1:SLOT_W]);
    cfg.coef[6]     = coef_entry(coef_pair_67[SLOT_W-1:0]);
    cfg.coef[7]     = coef_entry(coef_pair_67[2*SLOT_W-1:SLOT_W]);
    cfg.coef[8]     = coef_entry(coef_last);
    cfg.thresh      = threshold_sq;
    cfg.model_valid = model_valid;
  end

endmodule

FILE: hdl/eit_pipe_ctrl.sv
// Pipeline control: valid bit of every stage and the per-stage advance chain.
`timescale 1ns / 1ps
module eit_pipe_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     out_ready,
  output logic [eit_pkg::NSTG-1:0] adv,
  output logic [eit_pkg::NSTG-1:0] valid
);
  import eit_pkg::*;

  // A stage loads when it is empty or the stage after it moves on.
  always_comb begin
    adv[NSTG-1] = !valid[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !valid[k] || adv[k+1];
    end
  end

  // Valid bits move along with their words.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  // Only an occupied stage may hold back.
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    ((~adv) & (~valid)) == '0)
    else $error("empty pipeline stage is stalled");

  // At most one word enters and one leaves per cycle.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ($countones(valid) <= $past($countones(valid)) + 1) &&
             ($countones(valid) + 1 >= $past($countones(valid))))
    else $error("pipeline occupancy jumped by more than one");
`endif

endmodule

FILE: hdl/eit_line.sv
// Epipolar line generation: both lines F*a and F^T*b in two stages.
`timescale 1ns / 1ps
module eit_line (
  input  logic                              clk,
  input  logic [eit_pkg::LINE_STG-1:0]      adv,
  input  logic [8:0][eit_pkg::SLOT_W-1:0]   coef,
  input  logic [eit_pkg::CRD_W-1:0]         ax,
  input  logic [eit_pkg::CRD_W-1:0]         ay,
  input  logic [eit_pkg::CRD_W-1:0]         bx,
  input  logic [eit_pkg::CRD_W-1:0]         by,
  output logic signed [eit_pkg::LINE_W-1:0] a1,
  output logic signed [eit_pkg::LINE_W-1:0] b1,
  output logic signed [eit_pkg::LINE_W-1:0] c1,
  output logic signed [eit_pkg::LINE_W-1:0] a2,
  output logic signed [eit_pkg::LINE_W-1:0] b2,
  output logic signed [eit_pkg::LINE_W-1:0] c2,
  output logic [eit_pkg::CRD_W-1:0]         ax_q,
  output logic [eit_pkg::CRD_W-1:0]         ay_q,
  output logic [eit_pkg::CRD_W-1:0]         bx_q,
  output logic [eit_pkg::CRD_W-1:0]         by_q
);
  import eit_pkg::*;

  logic signed [PROD1_W-1:0] prod [12];
  logic [CRD_W-1:0]          ax_s1, ay_s1, bx_s1, by_s1;

  // Signed entry times unsigned coordinate.
  function automatic logic signed [PROD1_W-1:0] mulc(input logic [SLOT_W-1:0] e,
                                                     input logic [CRD_W-1:0]  x);
    logic signed [PROD1_W-1:0] p;
    p = PROD1_W'($signed(e)) * PROD1_W'($signed({1'b0, x}));
    return p;
  endfunction

  function automatic logic signed [LINE_W-1:0] ext(input logic signed [PROD1_W-1:0] p);
    return LINE_W'(p);
  endfunction

  // Stage one: the twelve entry-coordinate products.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      prod[0]  <= mulc(coef[0], ax);
      prod[1]  <= mulc(coef[1], ay);
      prod[2]  <= mulc(coef[3], ax);
      prod[3]  <= mulc(coef[4], ay);
      prod[4]  <= mulc(coef[6], ax);
      prod[5]  <= mulc(coef[7], ay);
      prod[6]  <= mulc(coef[0], bx);
      prod[7]  <= mulc(coef[3], by);
      prod[8]  <= mulc(coef[1], bx);
      prod[9]  <= mulc(coef[4], by);
      prod[10] <= mulc(coef[2], bx);
      prod[11] <= mulc(coef[5], by);
      ax_s1    <= ax;
      ay_s1    <= ay;
      bx_s1    <= bx;
      by_s1    <= by;
    end
  end

  // Stage two: add the constant term to form each coefficient (third column of F for F*a, third row for F^T*b).
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      a1   <= ext(prod[0]) + ext(prod[1])  + LINE_W'($signed(coef[2]));
      b1   <= ext(prod[2]) + ext(prod[3])  + LINE_W'($signed(coef[5]));
      c1   <= ext(prod[4]) + ext(prod[5])  + LINE_W'($signed(coef[8]));
      a2   <= ext(prod[6]) + ext(prod[7])  + LINE_W'($signed(coef[6]));
      b2   <= ext(prod[8]) + ext(prod[9])  + LINE_W'($signed(coef[7]));
      c2   <= ext(prod[10]) + ext(prod[11]) + LINE_W'($signed(coef[8]));
      ax_q <= ax_s1;
      ay_q <= ay_s1;
      bx_q <= bx_s1;
      by_q <= by_s1;
    end
  end

endmodule

FILE: hdl/eit_side.sv
// One side of the test: squared residual against threshold times line norm.
`timescale 1ns / 1ps
module eit_side (
  input  logic                              clk,
  input  logic [eit_pkg::SIDE_STG-1:0]      adv,
  input  logic signed [eit_pkg::LINE_W-1:0] la,
  input  logic signed [eit_pkg::LINE_W-1:0] lb,
  input  logic signed [eit_pkg::LINE_W-1:0] lc,
  input  logic [eit_pkg::CRD_W-1:0]         px,
  input  logic [eit_pkg::CRD_W-1:0]         py,
  input  logic [eit_pkg::THR_W-1:0]         thresh,
  output logic                              ok,
  output logic                              degen
);
  import eit_pkg::*;

  localparam int AH_W = MAG_W - MAG_LO;

  logic [LINE_W-1:0]         a_abs, b_abs;
  logic [DOT_W-1:0]          d_abs;
  logic [NCHUNK*CHUNK_W-1:0] norm_pad;
  logic [WIDE_W-1:0]         lim_sum;

  // Stage one
  logic signed [DOT_W-1:0]  pa, pb;
  logic signed [LINE_W-1:0] c_s1;
  logic [MAG_W-1:0]         am, bm;
  // Stage two
  logic signed [DOT_W-1:0]  d;
  logic [2*AH_W-1:0]        a_hh, b_hh;
  logic [AH_W+MAG_LO-1:0]   a_hl, b_hl;
  logic [2*MAG_LO-1:0]      a_ll, b_ll;
  // Stage three
  logic [DMAG_W-1:0]        dm;
  logic [SQ_W-1:0]          asq, bsq;
  // Stage four
  logic [2*DHALF-1:0]       d_hh, d_hl, d_ll;
  logic [NORM_W-1:0]        norm;
  // Stage five
  logic [WIDE_W-1:0]        dsq5;
  logic [TPROD_W-1:0]       tprod [NCHUNK];
  logic                     degen5;
  // Stage six
  logic [WIDE_W-1:0]        dsq6, lim;
  logic                     degen6;

  always_comb begin
    a_abs    = la[LINE_W-1] ? LINE_W'(-la) : LINE_W'(la);
    b_abs    = lb[LINE_W-1] ? LINE_W'(-lb) : LINE_W'(lb);
    d_abs    = d[DOT_W-1] ? DOT_W'(-d) : DOT_W'(d);
    norm_pad = (NCHUNK * CHUNK_W)'(norm);
    lim_sum  = '0;
    for (int i = 0; i < NCHUNK; i++) begin
      lim_sum = lim_sum + (WIDE_W'(tprod[i]) << (i * CHUNK_W));
    end
  end

  // Stage one: coefficient times coordinate, and coefficient magnitudes.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pa   <= DOT_W'(la) * DOT_W'($signed({1'b0, px}));
      pb   <= DOT_W'(lb) * DOT_W'($signed({1'b0, py}));
      c_s1 <= lc;
      am   <= a_abs[MAG_W-1:0];
      bm   <= b_abs[MAG_W-1:0];
    end
  end

  // Stage two: residual sum, and partial products of the squares.
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      d    <= pa + pb + DOT_W'(c_s1);
      a_hh <= (2*AH_W)'(am[MAG_W-1:MAG_LO]) * (2*AH_W)'(am[MAG_W-1:MAG_LO]);
      a_hl <= (AH_W+MAG_LO)'(am[MAG_W-1:MAG_LO]) * (AH_W+MAG_LO)'(am[MAG_LO-1:0]);
      a_ll <= (2*MAG_LO)'(am[MAG_LO-1:0]) * (2*MAG_LO)'(am[MAG_LO-1:0]);
      b_hh <= (2*AH_W)'(bm[MAG_W-1:MAG_LO]) * (2*AH_W)'(bm[MAG_W-1:MAG_LO]);
      b_hl <= (AH_W+MAG_LO)'(bm[MAG_W-1:MAG_LO]) * (AH_W+MAG_LO)'(bm[MAG_LO-1:0]);
      b_ll <= (2*MAG_LO)'(bm[MAG_LO-1:0]) * (2*MAG_LO)'(bm[MAG_LO-1:0]);
    end
  end

  // Stage three: residual magnitude, and each square assembled.
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      dm  <= d_abs[DMAG_W-1:0];
      asq <= (SQ_W'(a_hh) << (2 * MAG_LO)) + (SQ_W'(a_hl) << (MAG_LO + 1)) + SQ_W'(a_ll);
      bsq <= (SQ_W'(b_hh) << (2 * MAG_LO)) + (SQ_W'(b_hl) << (MAG_LO + 1)) + SQ_W'(b_ll);
    end
  end

  // Stage four: partial products of the residual square, and the line norm.
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      d_hh <= (2*DHALF)'(dm[DMAG_W-1:DHALF]) * (2*DHALF)'(dm[DMAG_W-1:DHALF]);
      d_hl <= (2*DHALF)'(dm[DMAG_W-1:DHALF]) * (2*DHALF)'(dm[DHALF-1:0]);
      d_ll <= (2*DHALF)'(dm[DHALF-1:0]) * (2*DHALF)'(dm[DHALF-1:0]);
      norm <= NORM_W'(asq) + NORM_W'(bsq);
    end
  end

  // Stage five: residual square, threshold times each norm slice, and the zero-norm flag.
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      dsq5 <= (WIDE_W'(d_hh) << (2 * DHALF)) + (WIDE_W'(d_hl) << (DHALF + 1)) +
              WIDE_W'(d_ll);
      for (int i = 0; i < NCHUNK; i++) begin
        tprod[i] <= TPROD_W'(thresh) * TPROD_W'(norm_pad[i*CHUNK_W +: CHUNK_W]);
      end
      degen5 <= (norm == '0);
    end
  end

  // Stage six: the limit assembled from its slices.
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      dsq6   <= dsq5;
      lim    <= lim_sum;
      degen6 <= degen5;
    end
  end

  // Stage seven: the comparison.
  always_ff @(posedge clk) begin
    if (adv[6]) begin
      ok    <= (dsq6 <= lim);
      degen <= degen6;
    end
  end

`ifndef NO_ASSERTIONS
  // A zero norm always gives a zero limit.
  a_degen_zero_lim: assert property (@(posedge clk)
    degen6 |-> (lim == '0))
    else $error("degenerate line with nonzero limit");
`endif

endmodule

FILE: hdl/epipolar_inlier_test.sv
// Top level: symmetric epipolar distance check of point correspondences.
// Throughput: one correspondence per cycle; a stalled result holds only the full stages.
// The ten stages are two for the line products, seven per side, and one result register.
// Reset clears every stage valid bit and loads the register defaults (three-pixel limit).
`timescale 1ns / 1ps
module epipolar_inlier_test (
  input  logic                           clk,
  input  logic                           rst,
  eit_match_if.sink                      match_ch,
  eit_result_if.source                   result_ch,
  input  logic                           cfg_we,
  input  logic [eit_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [eit_pkg::CFG_DATA_W-1:0] cfg_data
);
  import eit_pkg::*;

  cfg_t                     cfg;
  logic [NSTG-1:0]          adv;
  logic [NSTG-1:0]          valid;
  logic signed [LINE_W-1:0] a1, b1, c1, a2, b2, c2;
  logic [CRD_W-1:0]         ax_q, ay_q, bx_q, by_q;
  logic                     ok1, ok2, dg1, dg2;
  logic [TAG_W-1:0]         tag_q [NSTG];
  logic                     inlier_q, degen_q;

  eit_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  eit_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (match_ch.valid),
    .out_ready (result_ch.ready),
    .adv       (adv),
    .valid     (valid)
  );

  eit_line u_line (
    .clk  (clk),
    .adv  (adv[LINE_STG-1:0]),
    .coef (cfg.coef),
    .ax   (match_ch.point_a_x),
    .ay   (match_ch.point_a_y),
    .bx   (match_ch.point_b_x),
    .by   (match_ch.point_b_y),
    .a1   (a1),
    .b1   (b1),
    .c1   (c1),
    .a2   (a2),
    .b2   (b2),
    .c2   (c2),
    .ax_q (ax_q),
    .ay_q (ay_q),
    .bx_q (bx_q),
    .by_q (by_q)
  );

  // Distance of point b from the line of point a.
  eit_side u_side_b (
    .clk    (clk),
    .adv    (adv[LINE_STG+SIDE_STG-1:LINE_STG]),
    .la     (a1),
    .lb     (b1),
    .lc     (c1),
    .px     (bx_q),
    .py     (by_q),
    .thresh (cfg.thresh),
    .ok     (ok2),
    .degen  (dg2)
  );

  // Distance of point a from the line of point b.
  eit_side u_side_a (
    .clk    (clk),
    .adv    (adv[LINE_STG+SIDE_STG-1:LINE_STG]),
    .la     (a2),
    .lb     (b2),
    .lc     (c2),
    .px     (ax_q),
    .py     (ay_q),
    .thresh (cfg.thresh),
    .ok     (ok1),
    .degen  (dg1)
  );

  // The tag rides along beside the datapath.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      tag_q[0] <= match_ch.match_tag;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (adv[k]) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  // Result register: the model must be valid, both sides must pass and neither line may be degenerate.
  always_ff @(posedge clk) begin
    if (adv[NSTG-1]) begin
      inlier_q <= cfg.model_valid && ok1 && ok2 && !dg1 && !dg2;
      degen_q  <= cfg.model_valid && (dg1 || dg2);
    end
  end

  assign match_ch.ready            = adv[0];
  assign result_ch.valid           = valid[NSTG-1];
  assign result_ch.tag_out         = tag_q[NSTG-1];
  assign result_ch.is_inlier       = inlier_q;
  assign result_ch.line_degenerate = degen_q;

`ifndef NO_ASSERTIONS
  // A degenerate line never reports an inlier.
  a_degen_not_inlier: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid |-> !(result_ch.is_inlier && result_ch.line_degenerate))
    else $error("result flagged both inlier and degenerate");
`endif

endmodule
